[rtl/opt_pkg.sv]
// Shared types and constants for the periodic and one-shot task timer.
package opt_pkg;

  // Operation codes carried in the func field of a request.
  localparam logic [1:0] FUNC_UPDATE   = 2'd0;
  localparam logic [1:0] FUNC_ONCE     = 2'd1;
  localparam logic [1:0] FUNC_PERIODIC = 2'd2;
  localparam logic [1:0] FUNC_DISARM   = 2'd3;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QDepth = 2;

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  slot;
    logic [31:0] interval_ms;
    logic [31:0] now_ms;
  } in_req_t;

  // Result as it leaves on the output channel.
  typedef struct packed {
    logic [2:0] fired_slot;
    logic       last;
  } out_res_t;

  // Command kinds after classification by the front.
  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_ARM_ONCE,
    CMD_ARM_PERIODIC,
    CMD_DISARM
  } cmd_e;

  // One queued command.
  typedef struct packed {
    cmd_e        kind;
    logic [2:0]  slot;
    logic [31:0] interval_ms;
    logic [31:0] now_ms;
  } cmd_t;

  // One slot of the timer table.
  typedef struct packed {
    logic        periodic;
    logic [31:0] period;
    logic [31:0] due;
  } slot_entry_t;

  // States of the back-end sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_e;

endpackage

[rtl/opt_front.sv]
// Front end: classifies requests, drops out-of-range ones and queues the rest.
module opt_front #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  opt_pkg::in_req_t in_req_i,
  output logic             q_valid_o,
  output opt_pkg::cmd_t    q_cmd_o,
  input  logic             q_pop_i
);
  import opt_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  cmd_t cmd;
  logic keep;
  logic full;
  logic push;

  // Classify the request; arm and disarm of a slot outside the table are dropped.
  always_comb begin
    cmd.slot        = in_req_i.slot;
    cmd.interval_ms = in_req_i.interval_ms;
    cmd.now_ms      = in_req_i.now_ms;
    case (in_req_i.func)
      FUNC_UPDATE:   cmd.kind = CMD_UPDATE;
      FUNC_ONCE:     cmd.kind = CMD_ARM_ONCE;
      FUNC_PERIODIC: cmd.kind = CMD_ARM_PERIODIC;
      FUNC_DISARM:   cmd.kind = CMD_DISARM;
      default:       cmd.kind = CMD_UPDATE;
    endcase
    keep = (in_req_i.func == FUNC_UPDATE) || (32'(in_req_i.slot) < 32'(NUM_SLOTS));
  end

  assign full       = (count_q == CntW'(QDepth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && keep;
  assign q_valid_o  = (count_q != '0);
  assign q_cmd_o    = entry_q[rd_ptr_q];

  // Queue pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !(q_pop_i && q_valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i && q_valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

[rtl/opt_back.sv]
// Back end: slot table, arm and disarm execution, and the update scan.
module opt_back #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  opt_pkg::cmd_t     q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output opt_pkg::out_res_t out_res_o
);
  import opt_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  back_state_e state_q, state_d;

  slot_entry_t          mem_q [NUM_SLOTS];
  slot_entry_t          rd_q;
  logic [IdxW-1:0]      rd_addr;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  slot_entry_t          mem_wdata;

  logic [NUM_SLOTS-1:0] armed_q, armed_d;
  logic [IdxW-1:0]      scan_idx_q, scan_idx_d;
  logic [31:0]          now_q, now_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]      pend_slot_q, pend_slot_d;
  logic                 out_vld_q;
  out_res_t             out_q;

  logic                 out_free;
  logic                 out_load;
  out_res_t             out_data;
  logic                 fire;
  logic                 advance;
  logic [IdxW-1:0]      arm_idx;

  assign arm_idx  = IdxW'(q_cmd_i.slot);
  assign out_free = !out_vld_q || !out_stall_i;
  assign fire     = armed_q[scan_idx_q] && (now_q >= rd_q.due);
  assign advance  = !fire || !pend_vld_q || out_free;

  // Sequencer: executes one command, or scans one slot per cycle on update while the output
  // does not block. A fired slot is held until the next fires or the scan ends, so the final one can carry last.
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = scan_idx_q;
    mem_wdata   = rd_q;
    armed_d     = armed_q;
    scan_idx_d  = scan_idx_q;
    now_d       = now_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    out_load    = 1'b0;
    out_data.fired_slot = 3'(pend_slot_q);
    out_data.last       = 1'b0;
    rd_addr     = '0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            CMD_UPDATE: begin
              now_d      = q_cmd_i.now_ms;
              scan_idx_d = '0;
              state_d    = BK_SCAN;
            end
            CMD_ARM_ONCE: begin
              mem_we             = 1'b1;
              mem_waddr          = arm_idx;
              mem_wdata.periodic = 1'b0;
              mem_wdata.period   = q_cmd_i.interval_ms;
              mem_wdata.due      = q_cmd_i.now_ms + q_cmd_i.interval_ms;
              armed_d[arm_idx]   = 1'b1;
            end
            CMD_ARM_PERIODIC: begin
              mem_we             = 1'b1;
              mem_waddr          = arm_idx;
              mem_wdata.periodic = 1'b1;
              mem_wdata.period   = q_cmd_i.interval_ms;
              mem_wdata.due      = q_cmd_i.now_ms;
              armed_d[arm_idx]   = 1'b1;
            end
            CMD_DISARM: begin
              armed_d[arm_idx] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (fire && advance) begin
          // Release the previous fired slot, then hold this one.
          if (pend_vld_q) begin
            out_load = 1'b1;
          end
          pend_vld_d  = 1'b1;
          pend_slot_d = scan_idx_q;
          if (rd_q.periodic) begin
            mem_we        = 1'b1;
            mem_wdata.due = rd_q.due + rd_q.period;
          end else begin
            armed_d[scan_idx_q] = 1'b0;
          end
        end
        if (advance) begin
          if (scan_idx_q == LastIdx) begin
            state_d = BK_FLUSH;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
            rd_addr    = scan_idx_q + 1'b1;
          end
        end else begin
          rd_addr = scan_idx_q;
        end
      end
      BK_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = BK_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_data.last = 1'b1;
          pend_vld_d    = 1'b0;
          state_d       = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      armed_q    <= '0;
      scan_idx_q <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      armed_q    <= armed_d;
      scan_idx_q <= scan_idx_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    pend_slot_q <= pend_slot_d;
    if (out_load) begin
      out_q <= out_data;
    end
  end

  // Slot table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

`ifndef ASSERT_OFF
  // No held result may be left behind when the sequencer goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> !pend_vld_q)
    else $error("held result lost at end of update");

  // A held result always comes from a slot already passed by the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN && pend_vld_q) |-> (pend_slot_q < scan_idx_q))
    else $error("held slot not behind scan position");

  // The scan index stays inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SCAN |-> scan_idx_q <= LastIdx)
    else $error("scan index out of range");

  // A scan step blocked by the output keeps its position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN && !advance) |=> (state_q == BK_SCAN && $stable(scan_idx_q)))
    else $error("scan moved while blocked");
`endif

endmodule

[rtl/once_periodic_task_timer.sv]
// Top level of the timer slot table: front end, command queue and back end.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o, payload
// in_req_i) carries an operation, a slot, an interval and the current time.
// Arm and disarm requests change one slot and give no result. An update
// request scans every slot in index order and gives one result on the output
// channel (out_valid_o / out_stall_i, payload out_res_o) for each slot that is
// due; the final result of an update has last set. An update with nothing due
// gives no result.
// Timing: the front queues up to two requests and takes one a cycle while
// room is left. The back executes an arm or disarm from idle and scans an
// update one slot per cycle, while the scan is not paused, through the
// table's registered read port. The first result of an update appears once a
// second due slot is found or the scan ends, since last is known only then.
// A stalled output holds its result; the scan pauses only when a new fired
// slot finds a held result while the output register is full and stalled.
// Reset clears all armed flags, the queue and the output register; the slot
// table contents are undefined until a slot is armed.
module once_periodic_task_timer #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  opt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output opt_pkg::out_res_t out_res_o
);
  import opt_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Classification and command queue.
  opt_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  // Slot table and scan engine.
  opt_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule
